// ----- hdl/set_assoc_cache_tag_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the set-associative cache tag controller
// thin wrappers that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define SACT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// condition that must never hold outside reset
`define SACT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define SACT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg)
`define SACT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/sact_pkg.sv -----
// ----------------------------------------------------------------------------
// sact_pkg
// types and constants shared by the cache tag controller files
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned COST_W   = 20;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MEM_CYC  = 100;
    localparam int unsigned WORD_B   = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [1:0] REG_WRITE_ALLOCATE   = 2'd0;
    localparam logic [1:0] REG_WRITE_THROUGH    = 2'd1;
    localparam logic [1:0] REG_FIFO_REPLACEMENT = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/sact_req_if.sv -----
// ----------------------------------------------------------------------------
// sact_req_if / sact_rsp_if
// valid-ready channels for requests and responses
// ----------------------------------------------------------------------------
interface sact_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [sact_pkg::ADDR_W-1:0] address;
    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

interface sact_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [sact_pkg::COST_W-1:0] cycle_cost;
    logic [sact_pkg::CNT_W-1:0]  load_count;
    logic [sact_pkg::CNT_W-1:0]  store_count;
    logic [sact_pkg::CNT_W-1:0]  load_hit_count;
    logic [sact_pkg::CNT_W-1:0]  load_misses;
    logic [sact_pkg::CNT_W-1:0]  store_hit_count;
    logic [sact_pkg::CNT_W-1:0]  store_misses;
    logic [sact_pkg::ACC_W-1:0]  total_cycle_count;
    modport source (output valid, hit, cycle_cost, load_count, store_count, load_hit_count,
                    load_misses, store_hit_count, store_misses, total_cycle_count,
                    input ready);
    modport sink   (input valid, hit, cycle_cost, load_count, store_count, load_hit_count,
                    load_misses, store_hit_count, store_misses, total_cycle_count,
                    output ready);
endinterface

// ----- hdl/set_assoc_cache_tag_controller_unit.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit
// tag-only set-associative cache with lru/fifo replacement and write policies
// ----------------------------------------------------------------------------
// One request transaction is taken, its set is read from a single set-wide
// memory (one row per set holding valid, dirty, tag, fill and use time for
// every way), the row is updated and written back, and one response
// transaction is offered. A request goes through a read, a modify/write and
// then the state in which the response is offered, where it stays as long as
// the response waits; the next request is taken once the response is gone.
// The set row memory is the limit: one read-modify-write per request. After
// reset a clearing pass walks the memory, one set per cycle, during which no
// request is taken; configuration writes are accepted throughout.
`include "set_assoc_cache_tag_controller_unit_macros.svh"

module set_assoc_cache_tag_controller_unit #(
    parameter int unsigned NUM_SETS    = 256,
    parameter int unsigned NUM_WAYS    = 4,
    parameter int unsigned BLOCK_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sact_req_if.sink    req,
    sact_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
    localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned SET_B  = $clog2(NUM_SETS);
    localparam int unsigned TAG_W  = sact_pkg::ADDR_W - OFF_W - SET_B;
    localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned XFER   = sact_pkg::MEM_CYC * (BLOCK_BYTES / sact_pkg::WORD_B);
    localparam int unsigned T_W    = sact_pkg::TIME_W;
    localparam int unsigned LINE_W = 2 + TAG_W + 2 * T_W;
    localparam int unsigned ROW_W  = LINE_W * NUM_WAYS;
    localparam logic [sact_pkg::COST_W-1:0] C_ONE  = sact_pkg::COST_W'(1);
    localparam logic [sact_pkg::COST_W-1:0] C_MEM  = sact_pkg::COST_W'(sact_pkg::MEM_CYC);
    localparam logic [sact_pkg::COST_W-1:0] C_XFER = sact_pkg::COST_W'(XFER);

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [T_W-1:0]   fill_time;
        logic [T_W-1:0]   use_time;
    } line_t;

    // configuration registers
    logic write_allocate_reg, write_through_reg, fifo_replacement_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_allocate_reg   <= 1'b1;
            write_through_reg    <= 1'b0;
            fifo_replacement_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3:2] == sact_pkg::REG_WRITE_ALLOCATE)
                write_allocate_reg <= pwdata[0];
            if (paddr[3:2] == sact_pkg::REG_WRITE_THROUGH)
                write_through_reg <= pwdata[0];
            if (paddr[3:2] == sact_pkg::REG_FIFO_REPLACEMENT)
                fifo_replacement_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            sact_pkg::REG_WRITE_ALLOCATE:   prdata[0] = write_allocate_reg;
            sact_pkg::REG_WRITE_THROUGH:    prdata[0] = write_through_reg;
            sact_pkg::REG_FIFO_REPLACEMENT: prdata[0] = fifo_replacement_reg;
            default:                        prdata = '0;
        endcase
    end

    // set row memory
    logic [ROW_W-1:0] row_mem [NUM_SETS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [SET_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_waddr] <= mem_wdata;
        rd_row_reg <= row_mem[mem_raddr];
    end

    // control
    sact_pkg::state_t state_reg, state_next;
    logic [SET_W:0]   clr_cnt_reg, clr_cnt_next;
    logic             cmd_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [T_W-1:0]   clock_reg, clock_next;
    logic [sact_pkg::CNT_W-1:0] cnt_reg [6];
    logic [sact_pkg::ACC_W-1:0] acc_reg;
    logic                       hit_reg;
    logic [sact_pkg::COST_W-1:0] cost_reg;

    logic [SET_W-1:0] req_set;
    logic [TAG_W-1:0] req_tag;
    generate
        if (NUM_SETS > 1)
        begin : g_set
            assign req_set = req.address[OFF_W +: SET_W];
        end
        else
        begin : g_noset
            assign req_set = '0;
        end
    endgenerate
    assign req_tag = req.address[sact_pkg::ADDR_W-1 -: TAG_W];

    line_t lines [NUM_WAYS];
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
            lines[w] = line_t'(rd_row_reg[w*LINE_W +: LINE_W]);
    end

    // hit search and victim choice
    logic             hit_c, any_inv;
    logic [WAY_W-1:0] hit_way, inv_way, old_way, vic_way;
    logic [T_W-1:0]   best_t;
    always_comb
    begin
        hit_c = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        old_way = '0;
        best_t = fifo_replacement_reg ? lines[0].fill_time : lines[0].use_time;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (lines[w].valid && lines[w].tag == tag_reg)
            begin
                hit_c = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!lines[w].valid)
            begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            if (fifo_replacement_reg ? (lines[w].fill_time < best_t)
                                     : (lines[w].use_time < best_t))
            begin
                old_way = WAY_W'(w);
                best_t = fifo_replacement_reg ? lines[w].fill_time : lines[w].use_time;
            end
        end
        vic_way = any_inv ? inv_way : old_way;
    end

    // update of the row, cost and counter increments
    logic [ROW_W-1:0]          new_row;
    logic [sact_pkg::COST_W-1:0] cost_c;
    logic [5:0]                bump;
    line_t                     upd;
    always_comb
    begin
        new_row = rd_row_reg;
        cost_c = C_ONE;
        bump = '0;
        upd = lines[hit_way];
        if (cmd_reg == sact_pkg::CMD_LOAD)
        begin
            bump[0] = 1'b1;
            bump[2] = hit_c;
            bump[3] = !hit_c;
        end
        else
        begin
            bump[1] = 1'b1;
            bump[4] = hit_c;
            bump[5] = !hit_c;
        end
        if (hit_c)
        begin
            upd.use_time = clock_reg;
            if (cmd_reg == sact_pkg::CMD_STORE)
            begin
                if (write_through_reg)
                    cost_c = C_MEM;
                else
                    upd.dirty = 1'b1;
            end
            new_row[hit_way*LINE_W +: LINE_W] = upd;
        end
        else if (cmd_reg == sact_pkg::CMD_STORE && !write_allocate_reg)
        begin
            cost_c = C_XFER;
        end
        else
        begin
            cost_c = C_ONE + C_XFER;
            if (cmd_reg == sact_pkg::CMD_STORE && write_through_reg)
                cost_c = cost_c + C_MEM;
            if (lines[vic_way].valid && lines[vic_way].dirty)
                cost_c = cost_c + C_XFER;
            upd.valid = 1'b1;
            upd.dirty = (cmd_reg == sact_pkg::CMD_STORE) && !write_through_reg;
            upd.tag = tag_reg;
            upd.fill_time = clock_reg;
            upd.use_time = clock_reg;
            new_row[vic_way*LINE_W +: LINE_W] = upd;
        end
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        clock_next = clock_reg;
        mem_we = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = new_row;
        mem_raddr = req_set;
        req.ready = 1'b0;
        unique case (state_reg)
            sact_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_cnt_reg[SET_W-1:0];
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (SET_W+1)'(NUM_SETS - 1))
                    state_next = sact_pkg::ST_IDLE;
            end
            sact_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    clock_next = clock_reg + 1'b1;
                    state_next = sact_pkg::ST_LOOKUP;
                end
            end
            sact_pkg::ST_LOOKUP:
            begin
                mem_we = 1'b1;
                state_next = sact_pkg::ST_OUT;
            end
            sact_pkg::ST_OUT:
            begin
                if (rsp.ready)
                    state_next = sact_pkg::ST_IDLE;
            end
            default: state_next = sact_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sact_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            clock_reg <= '0;
            acc_reg <= '0;
            for (int k = 0; k < 6; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clock_reg <= clock_next;
            if (state_reg == sact_pkg::ST_LOOKUP)
            begin
                for (int k = 0; k < 6; k++)
                    if (bump[k] && cnt_reg[k] != '1)
                        cnt_reg[k] <= cnt_reg[k] + 1'b1;
                // saturating accumulate
                if (acc_reg > ('1 - sact_pkg::ACC_W'(cost_c)))
                    acc_reg <= '1;
                else
                    acc_reg <= acc_reg + sact_pkg::ACC_W'(cost_c);
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == sact_pkg::ST_IDLE && req.valid)
        begin
            cmd_reg <= req.command;
            set_reg <= req_set;
            tag_reg <= req_tag;
        end
        if (state_reg == sact_pkg::ST_LOOKUP)
        begin
            hit_reg <= hit_c;
            cost_reg <= cost_c;
        end
    end

    assign rsp.valid = (state_reg == sact_pkg::ST_OUT);
    assign rsp.hit = hit_reg;
    assign rsp.cycle_cost = cost_reg;
    assign rsp.load_count = cnt_reg[0];
    assign rsp.store_count = cnt_reg[1];
    assign rsp.load_hit_count = cnt_reg[2];
    assign rsp.load_misses = cnt_reg[3];
    assign rsp.store_hit_count = cnt_reg[4];
    assign rsp.store_misses = cnt_reg[5];
    assign rsp.total_cycle_count = acc_reg;

    // checks
    `SACT_ASSERT_NEVER(a_no_req_busy, clk, rst_n, req.ready && rsp.valid, "request taken while busy")
    `SACT_ASSERT_IMP(a_lookup_to_out, clk, rst_n, state_reg == sact_pkg::ST_LOOKUP, ##1 rsp.valid, "response missing after lookup")
    `SACT_ASSERT_IMP(a_loads_split, clk, rst_n, rsp.valid && rsp.load_count != '1, rsp.load_count == rsp.load_hit_count + rsp.load_misses, "load counters disagree")
    `SACT_ASSERT_NEVER(a_hit_cost, clk, rst_n, rsp.valid && rsp.hit && rsp.cycle_cost != C_ONE && rsp.cycle_cost != C_MEM, "bad hit cost")

endmodule

// ----- bench/tb_set_assoc_cache_tag_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_controller_unit
// self-checking bench for the tag-only set-associative cache controller:
// a behavioural cache model predicts hit, cost and running counters for each
// request transaction, responses are checked in order, and the run walks
// through several write and replacement policy settings over the apb port
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_controller_unit;

    localparam int unsigned SETS    = 256;
    localparam int unsigned WAYS    = 4;
    localparam int unsigned LINES   = SETS * WAYS;
    localparam int unsigned XFER    = sact_pkg::MEM_CYC * (16 / sact_pkg::WORD_B);
    localparam int unsigned LIMIT   = 400000;
    localparam int unsigned N_RAND  = 170;

    // one expected response transaction
    typedef struct {
        logic                        hit;
        logic [sact_pkg::COST_W-1:0] cost;
        logic [sact_pkg::CNT_W-1:0]  cnt [6];
        logic [sact_pkg::ACC_W-1:0]  acc;
    } access_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    sact_req_if req ();
    sact_rsp_if rsp ();

    set_assoc_cache_tag_controller_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // cache model state
    logic                          mdl_valid [LINES];
    logic                          mdl_dirty [LINES];
    logic [19:0]                   mdl_tag   [LINES];
    logic [sact_pkg::TIME_W-1:0]   mdl_fill  [LINES];
    logic [sact_pkg::TIME_W-1:0]   mdl_use   [LINES];
    logic [sact_pkg::TIME_W-1:0]   mdl_clock;
    logic [sact_pkg::CNT_W-1:0]    mdl_cnt   [6];
    logic [sact_pkg::ACC_W-1:0]    mdl_acc;
    logic                          cfg_allocate, cfg_through, cfg_fifo;

    access_result_t pending_results [$];
    int unsigned    mismatches;
    int unsigned    cycles;
    int unsigned    hold_cycles;
    bit             no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // response ready: long hold-off when asked, else random idling unless no_idle is set
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 29);
    end

    task automatic report_field(input string fname, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", fname, exp_v, act_v);
        end
    endtask

    // response checker, oldest expectation first
    always @(posedge clk)
    begin
        access_result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response transaction with nothing expected");
            end
            else
            begin
                e = pending_results.pop_front();
                report_field("hit", e.hit, rsp.hit);
                report_field("cycle_cost", e.cost, rsp.cycle_cost);
                report_field("load_count", e.cnt[0], rsp.load_count);
                report_field("store_count", e.cnt[1], rsp.store_count);
                report_field("load_hit_count", e.cnt[2], rsp.load_hit_count);
                report_field("load_misses", e.cnt[3], rsp.load_misses);
                report_field("store_hit_count", e.cnt[4], rsp.store_hit_count);
                report_field("store_misses", e.cnt[5], rsp.store_misses);
                report_field("total_cycle_count", e.acc, rsp.total_cycle_count);
            end
        end
    end

    function automatic void count_up(input int k);
        if (mdl_cnt[k] != '1)
            mdl_cnt[k]++;
    endfunction

    // pick the way to fill: first invalid, else oldest fill or oldest use
    function automatic int choose_victim(input int base);
        int best;
        best = base;
        for (int w = 0; w < WAYS; w++)
            if (!mdl_valid[base + w])
                return base + w;
        for (int w = 1; w < WAYS; w++)
        begin
            if (cfg_fifo ? (mdl_fill[base + w] < mdl_fill[best])
                         : (mdl_use[base + w] < mdl_use[best]))
                best = base + w;
        end
        return best;
    endfunction

    // allocate a line, returning the write-back cost of a dirty victim
    function automatic int unsigned allocate_line(input int idx, input logic [19:0] t,
                                                  input logic d);
        int unsigned extra;
        extra = (mdl_valid[idx] && mdl_dirty[idx]) ? XFER : 0;
        mdl_valid[idx] = 1'b1;
        mdl_dirty[idx] = d;
        mdl_tag[idx]   = t;
        mdl_fill[idx]  = mdl_clock;
        mdl_use[idx]   = mdl_clock;
        return extra;
    endfunction

    // apply one access to the cache model and queue its response
    function automatic void predict_access(input logic cmd, input logic [31:0] addr);
        access_result_t r;
        logic [7:0]  set_idx;
        logic [19:0] t;
        int          base, found;
        logic        hit;
        longint unsigned cost;
        set_idx = addr[11:4];
        t       = addr[31:12];
        base    = set_idx * WAYS;
        found   = 0;
        hit     = 1'b0;
        mdl_clock++;
        for (int w = 0; w < WAYS; w++)
            if (!hit && mdl_valid[base + w] && mdl_tag[base + w] == t)
            begin
                hit   = 1'b1;
                found = base + w;
            end
        if (cmd == sact_pkg::CMD_LOAD)
        begin
            count_up(0);
            if (hit)
            begin
                count_up(2);
                mdl_use[found] = mdl_clock;
                cost = 1;
            end
            else
            begin
                count_up(3);
                cost = 1 + XFER + allocate_line(choose_victim(base), t, 1'b0);
            end
        end
        else
        begin
            count_up(1);
            if (hit)
            begin
                count_up(4);
                mdl_use[found] = mdl_clock;
                if (cfg_through)
                    cost = sact_pkg::MEM_CYC;
                else
                begin
                    mdl_dirty[found] = 1'b1;
                    cost = 1;
                end
            end
            else
            begin
                count_up(5);
                if (cfg_allocate)
                begin
                    cost = 1 + XFER + (cfg_through ? sact_pkg::MEM_CYC : 0);
                    cost += allocate_line(choose_victim(base), t, !cfg_through);
                end
                else
                    cost = XFER;
            end
        end
        if (cost > 20'hFFFFF)
            cost = 20'hFFFFF;
        if (mdl_acc > 48'hFFFF_FFFF_FFFF - cost)
            mdl_acc = 48'hFFFF_FFFF_FFFF;
        else
            mdl_acc += cost;
        r.hit  = hit;
        r.cost = cost[sact_pkg::COST_W-1:0];
        for (int k = 0; k < 6; k++)
            r.cnt[k] = mdl_cnt[k];
        r.acc = mdl_acc;
        pending_results.push_back(r);
    endfunction

    // offer one request transaction; returns at the edge that accepts it
    task automatic send_access(input logic cmd, input logic [31:0] addr);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) >= 29) ? 0 : $urandom_range(1, 4);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        predict_access(cmd, addr);
    endtask

    // stop offering and let every response drain before touching registers
    task automatic drain;
        req.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // apb write: setup then access phase, model updated alongside
    task automatic write_policy(input logic [1:0] idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sact_pkg::REG_WRITE_ALLOCATE:   cfg_allocate = val;
            sact_pkg::REG_WRITE_THROUGH:    cfg_through  = val;
            sact_pkg::REG_FIFO_REPLACEMENT: cfg_fifo     = val;
            default: ;
        endcase
    endtask

    task automatic set_policies(input logic alloc, input logic thru, input logic fifo);
        drain();
        write_policy(sact_pkg::REG_WRITE_ALLOCATE, alloc);
        write_policy(sact_pkg::REG_WRITE_THROUGH, thru);
        write_policy(sact_pkg::REG_FIFO_REPLACEMENT, fifo);
    endtask

    // directed: hits, dirty eviction under lru, address extremes
    task automatic test_directed;
        send_access(sact_pkg::CMD_LOAD, 32'h0000_0000);   // cold miss
        send_access(sact_pkg::CMD_LOAD, 32'h0000_000C);   // hit, same block
        send_access(sact_pkg::CMD_STORE, 32'h0000_0004);  // store hit marks dirty
        for (int t = 1; t <= 4; t++)                      // fill set 0, evict dirty tag 0
            send_access(sact_pkg::CMD_LOAD, {20'(t), 12'h000});
        send_access(sact_pkg::CMD_STORE, 32'h0000_5000);  // store miss allocates dirty
        send_access(sact_pkg::CMD_LOAD, 32'h0000_1000);   // miss now
        send_access(sact_pkg::CMD_LOAD, 32'hFFFF_FFFF);
        send_access(sact_pkg::CMD_STORE, 32'hFFFF_FFFF);
        send_access(sact_pkg::CMD_STORE, 32'hFFFF_FFF0);
        send_access(sact_pkg::CMD_LOAD, 32'hAAAA_AAAA);
        send_access(sact_pkg::CMD_STORE, 32'h5555_5555);
        send_access(sact_pkg::CMD_LOAD, 32'h5555_5550);
    endtask

    // random accesses, mostly confined to a few sets and tags so that hits,
    // conflicts and evictions are common; the rest spread over all addresses
    task automatic test_random(input int n);
        logic [31:0] a;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                a[31:12] = ($urandom_range(0, 15) == 0) ? 20'hFFFFF
                                                       : 20'($urandom_range(0, 7));
                a[11:4]  = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 3));
                a[3:0]   = 4'($urandom);
            end
            else
                a = $urandom;
            send_access(logic'($urandom_range(0, 1)), a);
        end
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure;
        hold_cycles = 300;
        test_random(N_RAND);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.command = sact_pkg::CMD_LOAD;
        req.address = '0;
        rsp.ready   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        cycles      = 0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < LINES; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_dirty[i] = 1'b0;
            mdl_tag[i]   = '0;
            mdl_fill[i]  = '0;
            mdl_use[i]   = '0;
        end
        for (int k = 0; k < 6; k++)
            mdl_cnt[k] = '0;
        mdl_clock    = '0;
        mdl_acc      = '0;
        cfg_allocate = 1'b1;
        cfg_through  = 1'b0;
        cfg_fifo     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset policies: write-allocate, write-back, lru
        test_directed();
        test_random(N_RAND);
        // no allocation, write-back, lru
        set_policies(1'b0, 1'b0, 1'b0);
        test_random(N_RAND);
        // everything set: allocate, write-through, fifo, with no idling
        set_policies(1'b1, 1'b1, 1'b1);
        no_idle = 1'b1;
        test_random(N_RAND);
        no_idle = 1'b0;
        // write-through without allocation
        set_policies(1'b0, 1'b1, 1'b0);
        test_random(N_RAND);
        // write-back with fifo, receiver held off for a while
        set_policies(1'b1, 1'b0, 1'b1);
        test_backpressure();
        set_policies(1'b0, 1'b1, 1'b1);
        test_random(N_RAND);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
